// ===== design/fpba_pkg.sv =====
// Package: shared codes and field types for the fit-policy block allocator.
`timescale 1ns / 1ps

package fpba_pkg;

  typedef logic [0:0]  req_type_t;
  typedef logic [3:0]  blk_id_t;
  typedef logic [15:0] size_value_t;
  typedef logic [1:0]  status_t;
  typedef logic [1:0]  fit_mode_t;
  typedef logic [4:0]  block_count_t;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  localparam req_type_t REQ_LOAD  = 1'b0;
  localparam req_type_t REQ_ALLOC = 1'b1;

  localparam fit_mode_t MODE_FIRST = 2'd0;
  localparam fit_mode_t MODE_BEST  = 2'd1;
  localparam fit_mode_t MODE_WORST = 2'd2;

  localparam status_t STATUS_LOADED  = 2'd0;
  localparam status_t STATUS_GRANTED = 2'd1;
  localparam status_t STATUS_NO_FIT  = 2'd2;

  localparam fit_mode_t    FIT_MODE_RESET    = MODE_FIRST;
  localparam block_count_t BLOCK_COUNT_RESET = 5'd16;

endpackage

// ===== design/fpba_in_if.sv =====
// Interface: request channel into the allocator.
`timescale 1ns / 1ps

interface fpba_in_if;
  logic                  valid;
  logic                  ready;
  fpba_pkg::req_type_t   req_type;
  fpba_pkg::blk_id_t     load_blk;
  fpba_pkg::size_value_t size_value;

  modport source (output valid, output req_type, output load_blk, output size_value,
                  input ready);
  modport sink   (input valid, input req_type, input load_blk, input size_value,
                  output ready);
endinterface

// ===== design/fpba_out_if.sv =====
// Interface: result channel out of the allocator.
`timescale 1ns / 1ps

interface fpba_out_if;
  logic                   valid;
  logic                   ready;
  fpba_pkg::status_t      status;
  fpba_pkg::blk_id_t      chosen_block;
  fpba_pkg::size_value_t  size_left;

  modport source (output valid, output status, output chosen_block, output size_left,
                  input ready);
  modport sink   (input valid, input status, input chosen_block, input size_left,
                  output ready);
endinterface

// ===== design/fit_policy_block_allocator_unit.sv =====
// Top level: block size table in a memory, scanned by first, best or worst fit.
//
// Usage: load requests (req_type 0) store a block size at load_blk; allocation
// requests (req_type 1) scan blocks 0 .. block_count-1 and carve size_value out
// of the block picked by fit_mode. Each request gives exactly one result.
// Channels: in_chan (sink) and out_chan (source), valid/ready; a request moves
// when valid and ready are both high. cfg_we/cfg_index/cfg_data write fit_mode
// (index 0) and block_count (index 1); the user must do so only while the block
// is idle, as the block itself does not enforce it.
// Steps: a load goes to the finish step, then its result enters the output
// register. An allocation reads one table entry per cycle from the memory
// (block_count capped at NUM_BLOCKS; none for block_count 0), compares each
// entry that it read, and then finishes the same way.
// Flow: one request at a time; in_chan.ready rises again in the cycle the
// result enters the output register.
// Stall: the output register holds a result until out_chan.ready; the next
// request is still accepted meanwhile and waits in its final step until the
// register frees up.
// Reset: rst_n clears control state and config (fit_mode 0, block_count 16);
// the size table is not cleared and must be loaded before it is scanned.
`timescale 1ns / 1ps

module fit_policy_block_allocator_unit #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  fpba_in_if.sink                             in_chan,
  fpba_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned VAL_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // size table
  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic [SIZE_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;

  logic [1:0]                state_r, state_nxt;
  fpba_pkg::fit_mode_t       fit_mode_r, fit_mode_nxt;
  fpba_pkg::block_count_t    block_count_r, block_count_nxt;

  fpba_pkg::req_type_t       req_type_r, req_type_nxt;
  fpba_pkg::blk_id_t         req_idx_r, req_idx_nxt;
  fpba_pkg::size_value_t     req_size_r, req_size_nxt;

  logic [CNT_W-1:0]          rd_cnt_r, rd_cnt_nxt;
  logic                      cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic                      found_r, found_nxt;
  logic [IDX_W-1:0]          pick_idx_r, pick_idx_nxt;
  logic [SIZE_BITS-1:0]      pick_val_r, pick_val_nxt;

  logic                      out_valid_r, out_valid_nxt;
  fpba_pkg::status_t         out_status_r, out_status_nxt;
  fpba_pkg::blk_id_t         out_block_r, out_block_nxt;
  fpba_pkg::size_value_t     out_left_r, out_left_nxt;

  logic [CNT_W-1:0]          count_sat;
  logic [VAL_W-1:0]          have_ext;
  logic [VAL_W-1:0]          pick_ext;
  logic [VAL_W-1:0]          req_ext;
  logic                      fits;
  logic                      take;
  logic                      in_acc;
  logic                      out_free;
  logic                      load_in_range;
  logic [SIZE_BITS-1:0]      load_val;
  logic [SIZE_BITS-1:0]      grant_val;

  assign in_chan.ready   = (state_r == ST_IDLE);
  assign in_acc          = in_chan.valid && in_chan.ready;
  assign out_free        = !out_valid_r || out_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.chosen_block = out_block_r;
  assign out_chan.size_left    = out_left_r;

  // cap the scan length at the table depth
  assign count_sat = (32'(block_count_r) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                        : CNT_W'(block_count_r);

  assign have_ext = VAL_W'(rd_data_r);
  assign pick_ext = VAL_W'(pick_val_r);
  assign req_ext  = VAL_W'(req_size_r);
  assign fits     = (have_ext >= req_ext);

  always_comb begin
    take = 1'b0;
    if (cmp_vld_r && fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        case (fit_mode_r)
          fpba_pkg::MODE_BEST:  take = (have_ext < pick_ext);
          fpba_pkg::MODE_WORST: take = (have_ext > pick_ext);
          default:              take = 1'b0;
        endcase
      end
    end
  end

  assign load_in_range = (32'(req_idx_r) < NUM_BLOCKS);
  assign load_val      = SIZE_BITS'(req_size_r);
  assign grant_val     = pick_val_r - SIZE_BITS'(req_size_r);
  assign rd_addr       = rd_cnt_r[IDX_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    fit_mode_nxt    = fit_mode_r;
    block_count_nxt = block_count_r;
    req_type_nxt    = req_type_r;
    req_idx_nxt     = req_idx_r;
    req_size_nxt    = req_size_r;
    rd_cnt_nxt      = rd_cnt_r;
    cmp_vld_nxt     = 1'b0;
    cmp_idx_nxt     = cmp_idx_r;
    found_nxt       = found_r;
    pick_idx_nxt    = pick_idx_r;
    pick_val_nxt    = pick_val_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_status_nxt  = out_status_r;
    out_block_nxt   = out_block_r;
    out_left_nxt    = out_left_r;
    mem_we          = 1'b0;
    mem_waddr       = pick_idx_r;
    mem_wdata       = grant_val;

    if (cfg_we) begin
      case (cfg_index)
        fpba_pkg::REG_FIT_MODE:    fit_mode_nxt    = cfg_data[1:0];
        fpba_pkg::REG_BLOCK_COUNT: block_count_nxt = cfg_data[4:0];
        default: ;
      endcase
    end

    // compare stage: each entry is compared in the cycle after its read
    if (take) begin
      found_nxt    = 1'b1;
      pick_idx_nxt = cmp_idx_r;
      pick_val_nxt = rd_data_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_type_nxt = in_chan.req_type;
          req_idx_nxt  = in_chan.load_blk;
          req_size_nxt = in_chan.size_value;
          rd_cnt_nxt   = '0;
          found_nxt    = 1'b0;
          state_nxt    = (in_chan.req_type == fpba_pkg::REQ_ALLOC) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (rd_cnt_r < count_sat) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_addr;
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
        end else if (!cmp_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (req_type_r == fpba_pkg::REQ_LOAD) begin
            out_status_nxt = fpba_pkg::STATUS_LOADED;
            out_block_nxt  = req_idx_r;
            out_left_nxt   = load_in_range ? 16'(load_val) : 16'd0;
            mem_we         = load_in_range;
            mem_waddr      = IDX_W'(req_idx_r);
            mem_wdata      = load_val;
          end else if (found_r) begin
            out_status_nxt = fpba_pkg::STATUS_GRANTED;
            out_block_nxt  = 4'(pick_idx_r);
            out_left_nxt   = 16'(grant_val);
            mem_we         = 1'b1;
          end else begin
            out_status_nxt = fpba_pkg::STATUS_NO_FIT;
            out_block_nxt  = 4'd0;
            out_left_nxt   = 16'd0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fit_mode_r    <= fpba_pkg::FIT_MODE_RESET;
      block_count_r <= fpba_pkg::BLOCK_COUNT_RESET;
      cmp_vld_r     <= 1'b0;
      found_r       <= 1'b0;
      rd_cnt_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fit_mode_r    <= fit_mode_nxt;
      block_count_r <= block_count_nxt;
      cmp_vld_r     <= cmp_vld_nxt;
      found_r       <= found_nxt;
      rd_cnt_r      <= rd_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_type_r   <= req_type_nxt;
    req_idx_r    <= req_idx_nxt;
    req_size_r   <= req_size_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    pick_idx_r   <= pick_idx_nxt;
    pick_val_r   <= pick_val_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    out_left_r   <= out_left_nxt;
  end

endmodule

// ===== design/fpba_checker.sv =====
// Checker: port-level assertions for the allocator, bound to the top level.
`timescale 1ns / 1ps

module fpba_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input fpba_pkg::status_t      out_status,
  input fpba_pkg::blk_id_t      out_block,
  input fpba_pkg::size_value_t  out_left
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_block) && $stable(out_left))
    else $error("stalled result changed");

  // one request at a time: accepting drops ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request was accepted");

  // a miss reports block 0 and size 0
  a_no_fit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fpba_pkg::STATUS_NO_FIT) |->
      (out_block == 4'd0) && (out_left == 16'd0))
    else $error("no-fit result carries a block or size");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_block  (out_chan.chosen_block),
  .out_left   (out_chan.size_left)
);

// ===== tb/tb_fit_policy_block_allocator_unit.sv =====
// Testbench: table-driven and random requests against the fit-policy block allocator.
`timescale 1ns / 1ps

module tb_fit_policy_block_allocator_unit;
  import fpba_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 130;
  localparam int PRINT_CAP   = 100;

  // Mode code that the package leaves unnamed; it behaves as first fit.
  localparam fit_mode_t MODE_UNUSED = 2'd3;

  typedef struct packed {
    status_t      status;
    blk_id_t      chosen_block;
    size_value_t  size_left;
  } alloc_result_t;

  typedef struct packed {
    fit_mode_t     mode;
    block_count_t  count;
    req_type_t     kind;
    blk_id_t       idx;
    size_value_t   size;
    logic          typed;
    alloc_result_t want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fpba_in_if  in_chan ();
  fpba_out_if out_chan ();

  fit_policy_block_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block table and the registers.
  size_value_t   block_free [TABLE_DEPTH];
  fit_mode_t     mode_now;
  block_count_t  count_now;
  alloc_result_t pending_results [$];

  int  mismatch_count;
  int  cycle_count;
  bit  no_idle;
  bit  hold_output;

  // Fixed requests: extremes, every policy, zero count, zero request, unused mode.
  plan_row_t directed_plan [16] = '{
    '{MODE_FIRST,  5'd16, REQ_LOAD,  4'd0,  16'hFFFF, 1'b1, '{STATUS_LOADED, 4'd0,  16'hFFFF}},
    '{MODE_FIRST,  5'd16, REQ_LOAD,  4'd15, 16'h0000, 1'b1, '{STATUS_LOADED, 4'd15, 16'h0000}},
    '{MODE_FIRST,  5'd4,  REQ_LOAD,  4'd1,  16'h0005, 1'b1, '{STATUS_LOADED, 4'd1,  16'h0005}},
    '{MODE_FIRST,  5'd4,  REQ_LOAD,  4'd2,  16'h0003, 1'b1, '{STATUS_LOADED, 4'd2,  16'h0003}},
    '{MODE_FIRST,  5'd4,  REQ_LOAD,  4'd3,  16'h0005, 1'b1, '{STATUS_LOADED, 4'd3,  16'h0005}},
    '{MODE_FIRST,  5'd0,  REQ_ALLOC, 4'd0,  16'h0001, 1'b1, '{STATUS_NO_FIT, 4'd0,  16'h0000}},
    '{MODE_FIRST,  5'd4,  REQ_ALLOC, 4'd9,  16'h0000, 1'b1, '{STATUS_GRANTED, 4'd0, 16'hFFFF}},
    '{MODE_BEST,   5'd4,  REQ_ALLOC, 4'd0,  16'h0004, 1'b0, '0},
    '{MODE_WORST,  5'd4,  REQ_ALLOC, 4'd6,  16'h1000, 1'b0, '0},
    '{MODE_UNUSED, 5'd4,  REQ_ALLOC, 4'd0,  16'h0002, 1'b0, '0},
    '{MODE_BEST,   5'd4,  REQ_ALLOC, 4'd15, 16'hFFFF, 1'b1, '{STATUS_NO_FIT, 4'd0,  16'h0000}},
    '{MODE_BEST,   5'd4,  REQ_ALLOC, 4'd0,  16'h0003, 1'b0, '0},
    '{MODE_WORST,  5'd1,  REQ_ALLOC, 4'd0,  16'hEFFD, 1'b0, '0},
    '{MODE_FIRST,  5'd1,  REQ_LOAD,  4'd0,  16'h8000, 1'b1, '{STATUS_LOADED, 4'd0,  16'h8000}},
    '{MODE_WORST,  5'd4,  REQ_ALLOC, 4'd0,  16'h0005, 1'b0, '0},
    '{MODE_BEST,   5'd2,  REQ_ALLOC, 4'd3,  16'h0002, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  // Place one request in the shadow table and return the result it must give.
  function automatic alloc_result_t place_request(input req_type_t kind, input blk_id_t idx,
                                                  input size_value_t size);
    alloc_result_t r;
    int  span;
    int  pick;
    bit  found;
    r = '0;
    if (kind == REQ_LOAD) begin
      block_free[idx] = size;
      r = '{STATUS_LOADED, idx, size};
    end else begin
      span  = (count_now > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_now);
      found = 1'b0;
      pick  = 0;
      for (int k = 0; k < span; k++) begin
        if (block_free[k] < size) continue;
        if (!found) begin
          found = 1'b1;
          pick  = k;
          if (mode_now != MODE_BEST && mode_now != MODE_WORST) break;
        end else if (mode_now == MODE_BEST && block_free[k] < block_free[pick]) begin
          pick = k;
        end else if (mode_now == MODE_WORST && block_free[k] > block_free[pick]) begin
          pick = k;
        end
      end
      if (!found) begin
        r = '{STATUS_NO_FIT, 4'd0, 16'd0};
      end else begin
        block_free[pick] = block_free[pick] - size;
        r = '{STATUS_GRANTED, blk_id_t'(pick), block_free[pick]};
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Offer one request; called and returning at a falling edge with valid low.
  task automatic send_request(input req_type_t kind, input blk_id_t idx,
                              input size_value_t size, input logic typed,
                              input alloc_result_t want);
    int gap;
    alloc_result_t predicted;
    gap = draw_wait();
    repeat (gap) @(negedge clk);
    in_chan.valid      = 1'b1;
    in_chan.req_type   = kind;
    in_chan.load_blk   = idx;
    in_chan.size_value = size;
    do @(posedge clk); while (!in_chan.ready);
    predicted = place_request(kind, idx, size);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
    in_chan.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_config(input fit_mode_t mode, input block_count_t count);
    cfg_we    = 1'b1;
    cfg_index = REG_FIT_MODE;
    cfg_data  = '0;
    cfg_data[1:0] = mode;
    @(negedge clk);
    cfg_index = REG_BLOCK_COUNT;
    cfg_data  = count;
    @(negedge clk);
    cfg_we    = 1'b0;
    mode_now  = mode;
    count_now = count;
  endtask

  task automatic send_random_item();
    req_type_t    kind;
    blk_id_t      idx;
    size_value_t  size;
    int           pick;
    idx = blk_id_t'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 25) begin
      kind = REQ_LOAD;
      case ($urandom_range(0, 3))
        0:       size = 16'hFFFF;
        1:       size = 16'h0000;
        2:       size = size_value_t'($urandom_range(0, 300));
        default: size = size_value_t'($urandom);
      endcase
    end else begin
      kind = REQ_ALLOC;
      pick = $urandom_range(0, 15);
      case ($urandom_range(0, 6))
        0:       size = 16'h0000;
        1:       size = size_value_t'($urandom_range(1, 64));
        2:       size = block_free[pick];
        3:       size = block_free[pick] + 16'd1;
        4:       size = block_free[pick] - 16'd1;
        5:       size = 16'hFFFF;
        default: size = size_value_t'($urandom);
      endcase
    end
    send_request(kind, idx, size, 1'b0, '0);
  endtask

  // Result side: random stalls, one long hold-off on request, field checks.
  initial begin
    alloc_result_t want;
    int stall;
    out_chan.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_chan.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end
      stall = draw_wait();
      out_chan.ready = 1'b0;
      repeat (stall) @(negedge clk);
      out_chan.ready = 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: status %0d block %0d left %h",
                                  out_chan.status, out_chan.chosen_block, out_chan.size_left));
      end else begin
        want = pending_results.pop_front();
        if (out_chan.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_chan.status, want.status));
        if (out_chan.chosen_block !== want.chosen_block)
          report_mismatch($sformatf("chosen_block %0d, want %0d",
                                    out_chan.chosen_block, want.chosen_block));
        if (out_chan.size_left !== want.size_left)
          report_mismatch($sformatf("size_left %h, want %h", out_chan.size_left, want.size_left));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("tb_fit_policy_block_allocator_unit: FAIL");
    $finish;
  end

  initial begin
    plan_row_t    row;
    fit_mode_t    mode;
    block_count_t count;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_chan.valid      = 1'b0;
    in_chan.req_type   = REQ_LOAD;
    in_chan.load_blk   = '0;
    in_chan.size_value = '0;
    mismatch_count     = 0;
    cycle_count        = 0;
    no_idle            = 1'b0;
    hold_output        = 1'b0;
    mode_now           = FIT_MODE_RESET;
    count_now          = BLOCK_COUNT_RESET;
    foreach (block_free[k]) block_free[k] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.mode != mode_now || row.count != count_now) begin
        wait_drained();
        write_config(row.mode, row.count);
      end
      send_request(row.kind, row.idx, row.size, row.typed, row.want);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0:       begin mode = MODE_FIRST;  count = 5'd16; end
        1:       begin mode = MODE_BEST;   count = 5'd16; end
        2:       begin mode = MODE_WORST;  count = 5'd31; end
        3:       begin mode = MODE_UNUSED; count = 5'd1;  end
        4:       begin mode = MODE_BEST;   count = 5'd17; end
        5:       begin mode = MODE_WORST;  count = 5'd0;  end
        6:       begin mode = MODE_FIRST;  count = 5'd2;  end
        default: begin
          mode  = fit_mode_t'($urandom_range(0, 3));
          count = block_count_t'($urandom_range(0, 31));
        end
      endcase
      write_config(mode, count);
      no_idle = (p % 4 == 3);
      // Reload the whole table first so no scan reaches an unwritten entry.
      for (int b = 0; b < TABLE_DEPTH; b++)
        send_request(REQ_LOAD, blk_id_t'(b), size_value_t'($urandom), 1'b0, '0);
      // Stall the result side long enough to back up the request side.
      if (p == 2) hold_output = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 8 && n == PHASE_ITEMS / 2) wait_drained();
        send_random_item();
      end
    end

    wait_drained();
    repeat (2 * TABLE_DEPTH + 8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_fit_policy_block_allocator_unit: PASS");
    end else begin
      $display("tb_fit_policy_block_allocator_unit: FAIL");
    end
    $finish;
  end

endmodule
